### sv/sliding_window_latency_percentile_defines.svh
// Assertion helpers shared by swlp_ctrl and swlp_dp.
`ifndef SLIDING_WINDOW_LATENCY_PERCENTILE_DEFINES_SVH
`define SLIDING_WINDOW_LATENCY_PERCENTILE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SWLP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("swlp check failed");

// Next-cycle implication, checked outside reset.
`define SWLP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("swlp check failed");

`endif

### sv/swlp_pkg.sv
package swlp_pkg;

  localparam int unsigned DEF_WINDOW = 256;
  localparam int unsigned LAT_W      = 32;
  localparam int unsigned FILL_W     = 9;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DROP,
    S_INS,
    S_OUT
  } swlp_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;    // latch sample, read oldest ring word
    logic drop;    // remove oldest from sorted cells, write ring
    logic insert;  // insert new sample into sorted cells
    logic pick;    // load result registers
  } swlp_cmd_t;

endpackage

### sv/swlp_ctrl.sv
module swlp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output swlp_pkg::swlp_cmd_t cmd
);
  import swlp_pkg::*;
  `include "sliding_window_latency_percentile_defines.svh"

  swlp_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DROP;
        end
      end
      S_DROP: begin
        cmd.drop  = 1'b1;
        state_nxt = S_INS;
      end
      S_INS: begin
        cmd.insert = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.pick      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

  `SWLP_ASSERT_NEXT(a_accept_leaves_idle, in_valid && in_ready, state_r == S_DROP)
  `SWLP_ASSERT_NEXT(a_pick_sets_valid, cmd.pick, out_valid_r)
  `SWLP_ASSERT_NOW(a_ready_only_idle, in_ready, state_r == S_IDLE && !cmd.pick)
endmodule

### sv/swlp_dp.sv
module swlp_dp #(
  parameter int unsigned WINDOW = swlp_pkg::DEF_WINDOW
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  swlp_pkg::swlp_cmd_t         cmd,
  input  logic [swlp_pkg::LAT_W-1:0]  in_latency_ns,
  output logic [swlp_pkg::LAT_W-1:0]  out_p99_ns,
  output logic [swlp_pkg::LAT_W-1:0]  out_p50_ns,
  output logic [swlp_pkg::FILL_W-1:0] out_window_fill
);
  import swlp_pkg::*;
  `include "sliding_window_latency_percentile_defines.svh"

  localparam int unsigned AW = $clog2(WINDOW);
  localparam int unsigned CW = $clog2(WINDOW + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(WINDOW);

  // ring of samples in arrival order
  logic [LAT_W-1:0] ring [WINDOW];
  logic [LAT_W-1:0] old_r;
  logic [LAT_W-1:0] key_r;
  logic [AW-1:0]    pos_r;
  logic [CW-1:0]    count_r;
  logic             full_r;
  logic [AW-1:0]    r99_r;   // floor(99*(n-1)/100)
  logic [6:0]       acc_r;   // 99*(n-1) mod 100

  // sorted cells
  logic [LAT_W-1:0] cell_r   [WINDOW];
  logic [LAT_W-1:0] cell_nxt [WINDOW];
  logic [WINDOW-1:0] gt;
  logic [CW-1:0]    eff_cnt;

  logic [LAT_W-1:0] p99_r, p50_r;
  logic [CW-1:0]    fill_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      old_r <= ring[pos_r];
    end
    if (cmd.drop) begin
      ring[pos_r] <= key_r;
    end
  end

  // sorted view has one entry fewer after the drop when full
  assign eff_cnt = full_r ? FULL_CNT - CW'(1) : count_r;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    assign gt[i] = (CW'(i) >= eff_cnt) || (cell_r[i] > key_r);
    always_comb begin
      cell_nxt[i] = cell_r[i];
      if (cmd.drop && full_r) begin
        if (i < WINDOW - 1) begin
          if (cell_r[(i < WINDOW - 1) ? i + 1 : i] > old_r) begin
            cell_nxt[i] = cell_r[(i < WINDOW - 1) ? i + 1 : i];
          end
        end
      end else if (cmd.insert && gt[i]) begin
        if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
          cell_nxt[i] = cell_r[(i > 0) ? i - 1 : 0];
        end else begin
          cell_nxt[i] = key_r;
        end
      end
    end
    always_ff @(posedge clk) begin
      cell_r[i] <= cell_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r  <= in_latency_ns;
    end
    if (cmd.pick) begin
      p99_r  <= cell_r[r99_r];
      p50_r  <= cell_r[AW'(count_r >> 1)];
      fill_r <= count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      count_r <= '0;
      full_r  <= 1'b0;
      r99_r   <= '0;
      acc_r   <= '0;
    end else begin
      if (cmd.load) begin
        full_r <= (count_r == FULL_CNT);
      end
      if (cmd.drop) begin
        pos_r <= (pos_r == AW'(WINDOW - 1)) ? '0 : pos_r + AW'(1);
      end
      if (cmd.insert && !full_r) begin
        count_r <= count_r + CW'(1);
        if (count_r != '0) begin
          // 99*(n-1) grows by 99
          if (acc_r == 7'd0) begin
            acc_r <= 7'd99;
          end else begin
            acc_r <= acc_r - 7'd1;
            r99_r <= r99_r + AW'(1);
          end
        end
      end
    end
  end

  assign out_p99_ns      = p99_r;
  assign out_p50_ns      = p50_r;
  assign out_window_fill = FILL_W'(fill_r);

  `SWLP_ASSERT_NOW(a_count_bound, 1'b1, count_r <= FULL_CNT)
  `SWLP_ASSERT_NOW(a_rank_bound, count_r != '0, CW'(r99_r) < count_r)
  `SWLP_ASSERT_NEXT(a_full_keeps_count, cmd.insert && full_r, count_r == FULL_CNT)
endmodule

### sv/sliding_window_latency_percentile.sv
// Sliding-window latency percentile tracker.
// Input channel: in_valid/in_ready with in_latency_ns, one 32-bit ns sample
// per word. Output channel: out_valid/out_ready with out_p99_ns, out_p50_ns
// and out_window_fill, one result word per input word.
// The last WINDOW samples sit in a ring memory; a sorted copy lives in a
// row of compare-and-shift cells. Per sample: accept (ring read of the
// oldest word), drop pass (oldest removed when the window is full, ring
// written), insert pass, then result pick from the cells.
// One sample is in flight at a time: a new sample is accepted only in
// idle, after the previous one has finished its drop and insert passes
// through the sorted cells and its result pick.
// p99 is the value at rank floor(99*(n-1)/100), p50 at rank floor(n/2);
// the p99 rank is tracked incrementally as the window fills.
// Reset (rst_n low, synchronous) empties the window: fill count, ring
// pointer and rank trackers clear; memory contents are not cleared and
// need no clearing pass. When the receiver stalls, the result is held
// in the output register; the next sample is still taken and waits in
// its pick step until the output register is free.
module sliding_window_latency_percentile #(
  parameter int unsigned WINDOW = swlp_pkg::DEF_WINDOW
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [swlp_pkg::LAT_W-1:0]  in_latency_ns,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [swlp_pkg::LAT_W-1:0]  out_p99_ns,
  output logic [swlp_pkg::LAT_W-1:0]  out_p50_ns,
  output logic [swlp_pkg::FILL_W-1:0] out_window_fill
);
  import swlp_pkg::*;

  swlp_cmd_t cmd;

  swlp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  swlp_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_latency_ns   (in_latency_ns),
    .out_p99_ns      (out_p99_ns),
    .out_p50_ns      (out_p50_ns),
    .out_window_fill (out_window_fill)
  );
endmodule
